@@ rtl/core/emq_pkg.sv @@
// Package with request and result types and code constants for the expiring message queue.
`default_nettype none

package emq_pkg;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] now_time;
    logic [15:0] task_id;
  } emq_in_t;

  typedef struct packed {
    logic [15:0] popped_task;
    logic [1:0]  status;
    logic [4:0]  message_count;
    logic        has_message;
  } emq_out_t;

  localparam logic [1:0] MODE_ADD   = 2'd0;
  localparam logic [1:0] MODE_POP   = 2'd1;
  localparam logic [1:0] MODE_QUERY = 2'd2;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  localparam logic [31:0] TTL_RESET = 32'd1000;

endpackage

`default_nettype wire

@@ rtl/core/expiring_message_queue_core.sv @@
// Top level: expiring task queue kept as a ring in one synchronous memory.
// An add or query first runs the expiry scan over the entries held before it, and the scan
// reads one stored entry per cycle. A pop passes S_POP_RD and S_POP_DATA, an empty pop or
// unused mode goes straight to S_DONE; the next request is taken once S_DONE returns to S_IDLE.
// One request is in work at a time; a finished result may wait in the output register.
// Synchronous active-low reset empties the queue and sets time_to_live to 1000 ticks.
`default_nettype none

module expiring_message_queue_core #(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  emq_pkg::emq_in_t    in_data,
  output logic                out_valid,
  input  wire                 out_stall,
  output emq_pkg::emq_out_t   out_data,
  input  wire                 cfg_we,
  input  wire  [31:0]         cfg_wdata
);
  import emq_pkg::*;

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [15:0] task_id;
    logic [31:0] stamp;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_POP_RD,
    S_POP_DATA,
    S_DONE
  } state_t;

  entry_t entry_mem [QUEUE_DEPTH];
  entry_t rd_data_r;

  state_t         state_r;
  logic [1:0]     mode_r;
  logic [31:0]    now_r;
  logic [15:0]    task_r;
  logic [AW-1:0]  head_r;
  logic [CW-1:0]  count_r;
  logic [CW-1:0]  issue_r;
  logic [CW-1:0]  keep_r;
  logic           rvalid_r;
  logic [31:0]    ttl_r;
  logic [15:0]    popped_r;
  logic [1:0]     status_r;
  logic           out_valid_r;
  emq_out_t       out_data_r;

  logic           rd_en;
  logic [AW-1:0]  rd_addr;
  logic           wr_en;
  logic [AW-1:0]  wr_addr;
  entry_t         wr_data;
  logic [31:0]    diff;
  logic           keep;
  logic           scan_done;
  logic           room;

  function automatic logic [AW-1:0] ring_addr(input logic [AW-1:0] base,
                                               input logic [CW-1:0] offset);
    logic [CW:0] sum;
    sum = (CW+1)'(base) + (CW+1)'(offset);
    if (sum >= (CW+1)'(QUEUE_DEPTH)) begin
      sum = sum - (CW+1)'(QUEUE_DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  assign diff = (rd_data_r.stamp >= now_r) ? (rd_data_r.stamp - now_r)
                                           : (now_r - rd_data_r.stamp);
  assign keep      = (state_r == S_SCAN) && rvalid_r && (diff <= ttl_r);
  assign scan_done = (state_r == S_SCAN) && !rvalid_r && (issue_r >= count_r);
  assign room      = keep_r < CW'(QUEUE_DEPTH);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = head_r;
    wr_en   = 1'b0;
    wr_addr = ring_addr(head_r, keep_r);
    wr_data = rd_data_r;
    if (state_r == S_SCAN && issue_r < count_r) begin
      rd_en   = 1'b1;
      rd_addr = ring_addr(head_r, issue_r);
    end else if (state_r == S_POP_RD) begin
      rd_en = 1'b1;
    end
    if (keep) begin
      wr_en = 1'b1;
    end else if (scan_done && mode_r == MODE_ADD && room) begin
      wr_en   = 1'b1;
      wr_data = '{task_id: task_r, stamp: now_r};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= entry_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      rvalid_r    <= 1'b0;
      ttl_r       <= TTL_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        ttl_r <= cfg_wdata;
      end
      if (out_valid_r && !out_stall && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            mode_r   <= in_data.mode;
            now_r    <= in_data.now_time;
            task_r   <= in_data.task_id;
            popped_r <= '0;
            status_r <= STATUS_OK;
            issue_r  <= '0;
            keep_r   <= '0;
            rvalid_r <= 1'b0;
            if (in_data.mode == MODE_ADD || in_data.mode == MODE_QUERY) begin
              state_r <= S_SCAN;
            end else if (in_data.mode == MODE_POP) begin
              if (count_r == '0) begin
                status_r <= STATUS_EMPTY;
                state_r  <= S_DONE;
              end else begin
                state_r <= S_POP_RD;
              end
            end else begin
              state_r <= S_DONE;
            end
          end
        end
        S_SCAN: begin
          rvalid_r <= rd_en;
          if (rd_en) begin
            issue_r <= issue_r + CW'(1);
          end
          if (keep) begin
            keep_r <= keep_r + CW'(1);
          end
          if (scan_done) begin
            state_r <= S_DONE;
            if (mode_r == MODE_ADD && room) begin
              count_r <= keep_r + CW'(1);
            end else begin
              count_r <= keep_r;
              if (mode_r == MODE_ADD) begin
                status_r <= STATUS_FULL;
              end
            end
          end
        end
        S_POP_RD: begin
          state_r <= S_POP_DATA;
        end
        S_POP_DATA: begin
          popped_r <= rd_data_r.task_id;
          head_r   <= ring_addr(head_r, CW'(1));
          count_r  <= count_r - CW'(1);
          state_r  <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r              <= 1'b1;
            out_data_r.popped_task   <= popped_r;
            out_data_r.status        <= status_r;
            out_data_r.message_count <= 5'(count_r);
            out_data_r.has_message   <= (count_r != '0);
            state_r                  <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

@@ rtl/core/emq_checker.sv @@
// Port-level checker for the expiring message queue and its bind to the top level.
`default_nettype none

module emq_checker #(
  parameter int QUEUE_DEPTH = 16
) (
  input wire                clk,
  input wire                rst_n,
  input wire                in_valid,
  input wire                in_stall,
  input wire                out_valid,
  input wire                out_stall,
  input emq_pkg::emq_out_t  out_data
);
  import emq_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  a_has_message: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.has_message == (out_data.message_count != 5'd0))
    else $error("has_message disagrees with message_count");

  a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken while one is in work");

  a_popped_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != STATUS_OK |-> out_data.popped_task == 16'd0)
    else $error("failed request reports a popped task");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == STATUS_FULL
      |-> 32'(out_data.message_count) == 32'(QUEUE_DEPTH))
    else $error("dropped add while queue not full");

endmodule

bind expiring_message_queue_core emq_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_emq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
